[src/dda_pkg.sv]
// Package for the DDA line rasterizer: default sizes, register indexes and the sequencer state type.
package dda_pkg;

   // Default coordinate and fraction widths
   localparam int DEF_COORD_BITS = 10;
   localparam int DEF_FRAC_BITS  = 16;

   // Fixed field widths
   localparam int COLOR_W    = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 8;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_FIRST_X     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FIRST_Y     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SECOND_X    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SECOND_Y    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SCREEN_ROWS = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_LINE_COLOR  = 3'd5;

   // Line setup sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

endpackage

[src/dda_div.sv]
// Shared restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit per cycle.
module dda_div #(
   parameter int COORD_BITS = dda_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS  = dda_pkg::DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] dividend,   // must not exceed divisor
   input  logic [COORD_BITS-1:0] divisor,
   output logic                  done,
   output logic [FRAC_BITS:0]    quotient
);
   import dda_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 2);

   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [COORD_BITS-1:0] dvs_ff;
   logic [FRAC_BITS:0]    quo_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  done_ff;
   logic                  ge;
   logic [COORD_BITS:0]   diff;
   logic [COORD_BITS:0]   nrem;

   // Compare and subtract; the remainder stays below the divisor after each step
   always_comb begin
      ge     = rem_ff >= {1'b0, dvs_ff};
      diff   = rem_ff - {1'b0, dvs_ff};
      nrem   = ge ? diff : rem_ff;
      rem_in = {nrem[COORD_BITS-1:0], 1'b0};
   end

   // Step counter and finish pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_W'(1));
         if (start) begin
            cnt_ff <= CNT_W'(FRAC_BITS + 1);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   // Remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[FRAC_BITS-1:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/dda_line_rasterizer_top.sv]
// Top level of the DDA line rasterizer: config registers, setup sequencer, walker, output beat.
// Pull beat: registered at acceptance, out next cycle; one pull per cycle when idle and rsp taken.
// Restart beat: result registered at once, then the shared divider runs for the x axis and
// then the y axis before req_tready returns; a line with equal endpoints needs no division.
// Synchronous active-high reset clears control, positions, steps and registers (rows = 2^COORD_BITS).
module dda_line_rasterizer_top #(
   parameter int COORD_BITS = dda_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS  = dda_pkg::DEF_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dda_pkg::REQ_DATA_W-1:0]  req_tdata,   // [0] restart
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [((2*COORD_BITS+2+dda_pkg::COLOR_W+7)/8)*8-1:0] rsp_tdata,
                                           // pixel_x, pixel_row, pixel_color, zero pad
   output logic                            rsp_tlast,   // last_pixel
   output logic                            rsp_tuser,   // pixel_valid
   // configuration
   input  logic                            csr_we,
   input  logic [dda_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dda_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dda_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int F      = FRAC_BITS;
   localparam int POS_W  = C + F;
   localparam int STEP_W = F + 2;
   localparam int ROW_W  = C + 2;
   localparam int FLD_W  = C + ROW_W + COLOR_W;

   // Configuration registers
   logic [C-1:0]       first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic [C:0]         rows_ff;
   logic [COLOR_W-1:0] color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         second_x_ff <= '0;
         second_y_ff <= '0;
         rows_ff     <= (C+1)'(1) << C;
         color_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_FIRST_X:     first_x_ff  <= csr_wdata[C-1:0];
            REG_FIRST_Y:     first_y_ff  <= csr_wdata[C-1:0];
            REG_SECOND_X:    second_x_ff <= csr_wdata[C-1:0];
            REG_SECOND_Y:    second_y_ff <= csr_wdata[C-1:0];
            REG_SCREEN_ROWS: rows_ff     <= csr_wdata[C:0];
            REG_LINE_COLOR:  color_ff    <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Line state
   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_x_ff, pos_y_ff;
   logic [STEP_W-1:0]  step_x_ff, step_y_ff;
   logic [C:0]         left_ff;
   logic [C-1:0]       mag_y_ff;
   logic               neg_x_ff, neg_y_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [C-1:0]       out_x_ff;
   logic [ROW_W-1:0]   out_row_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_pix_ff, out_last_ff;

   logic in_fire, restart, pull_ok;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign in_fire    = req_tvalid && req_tready;
   assign restart    = req_tdata[0];
   assign pull_ok    = (left_ff != '0);

   // Endpoint order and deltas (walk starts at the endpoint with the greater x, the second one on a tie)
   logic [C-1:0] sx, sy, tx, ty, mag_x, mag_y, n_pix;
   logic [C:0]   dx, dy;
   logic         neg_x, neg_y;

   always_comb begin
      if (second_x_ff >= first_x_ff) begin
         sx = second_x_ff; sy = second_y_ff; tx = first_x_ff;  ty = first_y_ff;
      end else begin
         sx = first_x_ff;  sy = first_y_ff;  tx = second_x_ff; ty = second_y_ff;
      end
      dx    = {1'b0, tx} - {1'b0, sx};
      dy    = {1'b0, ty} - {1'b0, sy};
      neg_x = dx[C];
      neg_y = dy[C];
      mag_x = neg_x ? C'(-dx) : dx[C-1:0];
      mag_y = neg_y ? C'(-dy) : dy[C-1:0];
      n_pix = (mag_x >= mag_y) ? mag_x : mag_y;
   end

   // Sequencer: next state and control
   logic load_line, load_sx, load_sy, div_start, div_sel_y, div_done;

   always_comb begin
      state_in  = state_ff;
      load_line = 1'b0;
      load_sx   = 1'b0;
      load_sy   = 1'b0;
      div_start = 1'b0;
      div_sel_y = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_fire && restart) begin
               load_line = 1'b1;
               if (n_pix != '0) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV_X;
               end
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               load_sx   = 1'b1;
               div_start = 1'b1;
               div_sel_y = 1'b1;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               load_sy  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Shared divider
   logic [C-1:0] div_dividend, div_divisor;
   logic [F:0]   div_q;
   logic         div_neg;
   logic [STEP_W-1:0] step_mag, step_in;

   assign div_dividend = div_sel_y ? mag_y_ff : mag_x;
   assign div_divisor  = div_sel_y ? left_ff[C-1:0] : n_pix;

   dda_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Truncated quotient takes the sign of the delta
   assign div_neg  = load_sx ? neg_x_ff : neg_y_ff;
   assign step_mag = {1'b0, div_q};
   assign step_in  = div_neg ? -step_mag : step_mag;

   // Walk: next pixel position
   logic [POS_W-1:0] pos_x_in, pos_y_in;
   assign pos_x_in = pos_x_ff + {{(C-2){step_x_ff[STEP_W-1]}}, step_x_ff};
   assign pos_y_in = pos_y_ff + {{(C-2){step_y_ff[STEP_W-1]}}, step_y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         step_x_ff <= '0;
         step_y_ff <= '0;
         left_ff   <= '0;
      end else if (load_line) begin
         pos_x_ff  <= {sx, {F{1'b0}}};
         pos_y_ff  <= {sy, {F{1'b0}}};
         step_x_ff <= '0;
         step_y_ff <= '0;
         left_ff   <= {1'b0, n_pix};
      end else begin
         if (load_sx) begin
            step_x_ff <= step_in;
         end
         if (load_sy) begin
            step_y_ff <= step_in;
         end
         if (in_fire && !restart && pull_ok) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            left_ff  <= left_ff - (C+1)'(1);
         end
      end
   end

   // Setup operands kept for the second division and the step signs
   always_ff @(posedge clock) begin
      if (load_line) begin
         mag_y_ff <= mag_y;
         neg_x_ff <= neg_x;
         neg_y_ff <= neg_y;
      end
   end

   // Row: floor(rows - y), arithmetic shift of the fixed-point difference
   logic [POS_W+1:0] row_full;
   assign row_full = {1'b0, rows_ff, {F{1'b0}}} - {2'b00, pos_y_ff};

   // Output beat register
   logic emit;
   assign emit = in_fire && !restart && pull_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         out_x_ff     <= emit ? pos_x_ff[POS_W-1:F] : '0;
         out_row_ff   <= emit ? row_full[POS_W+1:F] : '0;
         out_color_ff <= emit ? color_ff : '0;
         out_pix_ff   <= emit;
         out_last_ff  <= emit && (left_ff == (C+1)'(1));
      end
   end

   always_comb begin
      rsp_tdata            = '0;
      rsp_tdata[FLD_W-1:0] = {out_color_ff, out_row_ff, out_x_ff};
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_pix_ff;

`ifndef SYNTHESIS
   // The divider finishes only while the sequencer waits on it
   a_div_done_in_setup: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_X || state_ff == ST_DIV_Y))
      else $error("divider finished outside line setup");

   // A restart with a nonempty line blocks the request side next cycle
   a_restart_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_fire && restart && n_pix != '0) |=> !req_tready)
      else $error("request accepted during line setup");

   // A beat without a pixel carries all-zero data
   a_empty_beat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_pix_ff) |-> (rsp_tdata == '0 && !out_last_ff))
      else $error("empty beat carries data");

   // Last pixel leaves the line exhausted
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (in_fire && emit && left_ff == (C+1)'(1)) |=> (left_ff == '0))
      else $error("pixel count not drained after last pixel");
`endif

endmodule
